### hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro expects i_clk and i_rst_n to exist in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define X86D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("x86d assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define X86D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("x86d assertion failed");

`endif

### hw/rtl/x86d_pkg.sv
// ----------------------------------------------------------------------------
// x86d_pkg
// Shared types, opcode patterns and classification functions of the decoder.
// ----------------------------------------------------------------------------
package x86d_pkg;

    localparam int X86D_QDEPTH = 4;

    // Opcode patterns, compared against the upper bits of the first byte.
    localparam logic [5:0] PAT_MOV_RM   = 6'b100010;
    localparam logic [3:0] PAT_MOV_IMMR = 4'b1011;
    localparam logic [5:0] PAT_IMM_RM   = 6'b100000;
    localparam logic [5:0] PAT_ADD_RM   = 6'b000000;
    localparam logic [6:0] PAT_ADD_ACC  = 7'b0000010;
    localparam logic [5:0] PAT_SUB_RM   = 6'b001010;
    localparam logic [6:0] PAT_SUB_ACC  = 7'b0010110;
    localparam logic [5:0] PAT_CMP_RM   = 6'b001110;
    localparam logic [6:0] PAT_CMP_ACC  = 7'b0011110;
    localparam logic [2:0] RM_DIRECT    = 3'b110;

    // Immediate sub-operation codes from ModRM bits 5..3.
    localparam logic [2:0] SUB_ADD = 3'b000;
    localparam logic [2:0] SUB_SUB = 3'b101;
    localparam logic [2:0] SUB_CMP = 3'b111;

    typedef enum logic [2:0] {
        KIND_REG_RM  = 3'd0,
        KIND_IMM_RM  = 3'd1,
        KIND_IMM_REG = 3'd2,
        KIND_IMM_ACC = 3'd3,
        KIND_INVALID = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_MOV = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_CMP = 2'd3
    } t_op;

    // Role of one code byte inside its instruction.
    typedef enum logic [2:0] {
        TAG_OPC     = 3'd0,
        TAG_MODRM   = 3'd1,
        TAG_DISP8   = 3'd2,
        TAG_DISP_LO = 3'd3,
        TAG_DISP_HI = 3'd4,
        TAG_IMM_LO  = 3'd5,
        TAG_IMM_SX  = 3'd6,
        TAG_IMM_HI  = 3'd7
    } t_tag;

    typedef struct packed {
        t_tag       tag;
        logic       last;
        logic [7:0] code_byte;
    } t_entry;

    typedef struct packed {
        logic [2:0]        inst_kind;
        logic [1:0]        operation;
        logic              dir_bit;
        logic              wide_bit;
        logic              sign_bit;
        logic [1:0]        mode_field;
        logic [2:0]        reg_num;
        logic [2:0]        rm_field;
        logic signed [15:0] displacement;
        logic [15:0]       immediate;
        logic [2:0]        inst_length;
    } t_result;

    function automatic t_kind x86d_kind(input logic [7:0] b);
        t_kind k;
        if (b[7:2] == PAT_MOV_RM)        k = KIND_REG_RM;
        else if (b[7:4] == PAT_MOV_IMMR) k = KIND_IMM_REG;
        else if (b[7:2] == PAT_IMM_RM)   k = KIND_IMM_RM;
        else if (b[7:2] == PAT_ADD_RM)   k = KIND_REG_RM;
        else if (b[7:1] == PAT_ADD_ACC)  k = KIND_IMM_ACC;
        else if (b[7:2] == PAT_SUB_RM)   k = KIND_REG_RM;
        else if (b[7:1] == PAT_SUB_ACC)  k = KIND_IMM_ACC;
        else if (b[7:2] == PAT_CMP_RM)   k = KIND_REG_RM;
        else if (b[7:1] == PAT_CMP_ACC)  k = KIND_IMM_ACC;
        else                             k = KIND_INVALID;
        return k;
    endfunction

    function automatic t_op x86d_op(input logic [7:0] b);
        t_op o;
        if (b[7:2] == PAT_ADD_RM || b[7:1] == PAT_ADD_ACC)      o = OP_ADD;
        else if (b[7:2] == PAT_SUB_RM || b[7:1] == PAT_SUB_ACC) o = OP_SUB;
        else if (b[7:2] == PAT_CMP_RM || b[7:1] == PAT_CMP_ACC) o = OP_CMP;
        else                                                    o = OP_MOV;
        return o;
    endfunction

    // Number of displacement bytes that follow a ModRM byte.
    function automatic logic [1:0] x86d_disp_bytes(input logic [7:0] modrm);
        logic [1:0] n;
        case (modrm[7:6])
            2'b01:   n = 2'd1;
            2'b10:   n = 2'd2;
            2'b00:   n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // True when the instruction carries a two-byte immediate.
    function automatic logic x86d_imm_two(input logic [7:0] opc);
        t_kind k;
        logic  two;
        k = x86d_kind(opc);
        if (k == KIND_IMM_REG)     two = opc[3];
        else if (k == KIND_IMM_RM) two = opc[0] & ~opc[1];
        else                       two = opc[0];
        return two;
    endfunction

endpackage

### hw/rtl/x86d_byte_if.sv
// ----------------------------------------------------------------------------
// x86d_byte_if
// Valid/ready channel that carries one code byte per word.
// ----------------------------------------------------------------------------
interface x86d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

### hw/rtl/x86d_inst_if.sv
// ----------------------------------------------------------------------------
// x86d_inst_if
// Valid/ready channel that carries one decoded instruction per word.
// ----------------------------------------------------------------------------
interface x86d_inst_if;
    logic               valid;
    logic               ready;
    logic [2:0]         inst_kind;
    logic [1:0]         operation;
    logic               dir_bit;
    logic               wide_bit;
    logic               sign_bit;
    logic [1:0]         mode_field;
    logic [2:0]         reg_num;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         inst_length;

    modport source (
        output valid, output inst_kind, output operation, output dir_bit,
        output wide_bit, output sign_bit, output mode_field, output reg_num,
        output rm_field, output displacement, output immediate,
        output inst_length, input ready
    );
    modport sink (
        input valid, input inst_kind, input operation, input dir_bit,
        input wide_bit, input sign_bit, input mode_field, input reg_num,
        input rm_field, input displacement, input immediate,
        input inst_length, output ready
    );
endinterface

### hw/rtl/x86_16bit_instruction_decoder.sv
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder
// 8086 decoder for MOV/ADD/SUB/CMP forms, fed one code byte per word.
// ----------------------------------------------------------------------------
// Usage: i_code delivers the code stream one byte per word; o_inst delivers
// one decoded instruction per word, after the last byte of that instruction.
// Opcode bytes that are not one of the decoded forms produce an invalid word
// of length 1 at once; a bad immediate sub-operation is consumed in full and
// reported as invalid with its complete length.
// Throughput: one code byte per cycle while the queue has room. The front part classifies
// each byte with a small pattern match and its phase register, so i_code
// takes a byte every cycle while the queue has room.
// Output: the last byte of an instruction is first written into the queue; once
// it is at the head of the queue and the result register is free, it is
// registered into the result register of the back part and o_inst.valid rises.
// Stalls: when o_inst is held off, the back part keeps consuming bytes that
// do not finish an instruction; the queue then fills and i_code.ready drops.
// Reset: synchronous, active low; the decoder expects an opcode byte, the
// queue is empty and o_inst.valid is low.
// ----------------------------------------------------------------------------
module x86_16bit_instruction_decoder #(
    parameter int QDEPTH = x86d_pkg::X86D_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    x86d_byte_if.sink   i_code,
    x86d_inst_if.source o_inst
);
    import x86d_pkg::*;

    // Front to queue.
    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;

    // Queue to back.
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    // The front part sees the stream in order and decides the role of every
    // byte; the tags it gives do not depend on the result side.
    x86d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code       (i_code),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    // The queue decouples the two parts so that a stalled result does not
    // stop byte intake until the queue is full.
    x86d_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    // The back part assembles fields and holds the finished result.
    x86d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_inst      (o_inst)
    );

endmodule

### hw/rtl/x86d_front.sv
// ----------------------------------------------------------------------------
// x86d_front
// Tracks the position inside the current instruction and tags each byte.
// ----------------------------------------------------------------------------
module x86d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    x86d_byte_if.sink        i_code,
    output logic             o_push_valid,
    output x86d_pkg::t_entry o_push_entry,
    input  logic             i_push_ready
);
    import x86d_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_MODRM   = 3'd1,
        PH_DISP_LO = 3'd2,
        PH_DISP_HI = 3'd3,
        PH_IMM_LO  = 3'd4,
        PH_IMM_HI  = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_opcode;
    logic [7:0] r_modrm;
    t_entry     entry;
    logic       accept;
    logic       imm_rm_op;
    logic [7:0] b;

    assign b            = i_code.code_byte;
    assign i_code.ready = i_push_ready;
    assign o_push_valid = i_code.valid;
    assign o_push_entry = entry;
    assign accept       = i_code.valid & i_push_ready;
    assign imm_rm_op    = (r_opcode[7:2] == PAT_IMM_RM);

    always_comb begin
        n_phase         = r_phase;
        entry.tag       = TAG_OPC;
        entry.last      = 1'b0;
        entry.code_byte = b;
        case (r_phase)
            PH_MODRM: begin
                entry.tag = TAG_MODRM;
                if (x86d_disp_bytes(b) != 2'd0) begin
                    n_phase = PH_DISP_LO;
                end else if (imm_rm_op) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    entry.last = 1'b1;
                    n_phase    = PH_OPCODE;
                end
            end
            PH_DISP_LO, PH_DISP_HI: begin
                if (r_phase == PH_DISP_HI) begin
                    entry.tag = TAG_DISP_HI;
                end else if (x86d_disp_bytes(r_modrm) == 2'd2) begin
                    entry.tag = TAG_DISP_LO;
                end else begin
                    entry.tag = TAG_DISP8;
                end
                if (entry.tag == TAG_DISP_LO) begin
                    n_phase = PH_DISP_HI;
                end else if (imm_rm_op) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    entry.last = 1'b1;
                    n_phase    = PH_OPCODE;
                end
            end
            PH_IMM_LO: begin
                if (x86d_imm_two(r_opcode)) begin
                    entry.tag = TAG_IMM_LO;
                    n_phase   = PH_IMM_HI;
                end else begin
                    // A byte immediate with s and w both set is sign-extended.
                    entry.tag  = (imm_rm_op && r_opcode[1:0] == 2'b11 && b[7])
                                 ? TAG_IMM_SX : TAG_IMM_LO;
                    entry.last = 1'b1;
                    n_phase    = PH_OPCODE;
                end
            end
            PH_IMM_HI: begin
                entry.tag  = TAG_IMM_HI;
                entry.last = 1'b1;
                n_phase    = PH_OPCODE;
            end
            default: begin
                // Expecting an opcode; unused phase codes land here as well.
                entry.tag = TAG_OPC;
                case (x86d_kind(b))
                    KIND_INVALID: begin
                        entry.last = 1'b1;
                        n_phase    = PH_OPCODE;
                    end
                    KIND_IMM_REG, KIND_IMM_ACC: n_phase = PH_IMM_LO;
                    default:                    n_phase = PH_MODRM;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opcode <= '0;
            r_modrm  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            if (entry.tag == TAG_OPC) begin
                r_opcode <= b;
                r_modrm  <= '0;
            end
            if (entry.tag == TAG_MODRM) begin
                r_modrm <= b;
            end
        end
    end

endmodule

### hw/rtl/x86d_queue.sv
// ----------------------------------------------------------------------------
// x86d_queue
// Small flip-flop FIFO of tagged bytes between the front and back parts.
// ----------------------------------------------------------------------------
module x86d_queue #(
    parameter int DEPTH = x86d_pkg::X86D_QDEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  x86d_pkg::t_entry i_push_entry,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output x86d_pkg::t_entry o_pop_entry,
    input  logic             i_pop_ready
);
    import x86d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/x86d_back.sv
// ----------------------------------------------------------------------------
// x86d_back
// Gathers instruction bytes by tag and registers the decoded result.
// ----------------------------------------------------------------------------
module x86d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    input  x86d_pkg::t_entry i_pop_entry,
    output logic             o_pop_ready,
    x86d_inst_if.source      o_inst
);
    import x86d_pkg::*;

    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;
    logic [2:0]  r_count, n_count;
    logic        r_out_valid;
    t_result     r_res, res;
    t_kind       kind;
    t_op         op;
    logic [7:0]  b;
    logic        out_free;
    logic        pop;

    assign b           = i_pop_entry.code_byte;
    assign out_free    = ~r_out_valid | o_inst.ready;
    assign o_pop_ready = ~i_pop_entry.last | out_free;
    assign pop         = i_pop_valid & o_pop_ready;

    // Field capture for the byte at the head of the queue.
    always_comb begin
        n_opcode = r_opcode;
        n_modrm  = r_modrm;
        n_disp   = r_disp;
        n_imm    = r_imm;
        n_count  = r_count + 3'd1;
        case (i_pop_entry.tag)
            TAG_OPC: begin
                n_opcode = b;
                n_modrm  = '0;
                n_disp   = '0;
                n_imm    = '0;
                n_count  = 3'd1;
            end
            TAG_MODRM:   n_modrm = b;
            TAG_DISP8:   n_disp  = {{8{b[7]}}, b};
            TAG_DISP_LO: n_disp  = {8'h00, b};
            TAG_DISP_HI: n_disp  = {b, r_disp[7:0]};
            TAG_IMM_LO:  n_imm   = {8'h00, b};
            TAG_IMM_SX:  n_imm   = {8'hFF, b};
            TAG_IMM_HI:  n_imm   = {b, r_imm[7:0]};
            default:     n_imm   = r_imm;
        endcase
    end

    // Result formed from the values as they stand after this byte.
    always_comb begin
        kind = x86d_kind(n_opcode);
        op   = x86d_op(n_opcode);
        if (kind == KIND_IMM_RM) begin
            case (n_modrm[5:3])
                SUB_ADD: op = OP_ADD;
                SUB_SUB: op = OP_SUB;
                SUB_CMP: op = OP_CMP;
                default: kind = KIND_INVALID;
            endcase
        end
        res             = '0;
        res.inst_kind   = kind;
        res.inst_length = n_count;
        if (kind != KIND_INVALID) begin
            res.operation = op;
        end
        case (kind)
            KIND_REG_RM, KIND_IMM_RM: begin
                res.wide_bit     = n_opcode[0];
                res.mode_field   = n_modrm[7:6];
                res.rm_field     = n_modrm[2:0];
                res.displacement = n_disp;
                if (kind == KIND_REG_RM) begin
                    res.dir_bit = n_opcode[1];
                    res.reg_num = n_modrm[5:3];
                end else begin
                    res.sign_bit  = n_opcode[1];
                    res.immediate = n_imm;
                end
            end
            KIND_IMM_REG: begin
                res.wide_bit  = n_opcode[3];
                res.reg_num   = n_opcode[2:0];
                res.immediate = n_imm;
            end
            KIND_IMM_ACC: begin
                res.wide_bit  = n_opcode[0];
                res.immediate = n_imm;
            end
            default: res.inst_length = n_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode    <= '0;
            r_modrm     <= '0;
            r_disp      <= '0;
            r_imm       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_opcode <= n_opcode;
                r_modrm  <= n_modrm;
                r_disp   <= n_disp;
                r_imm    <= n_imm;
                r_count  <= n_count;
            end
            if (pop && i_pop_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (o_inst.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_entry.last) begin
            r_res <= res;
        end
    end

    assign o_inst.valid        = r_out_valid;
    assign o_inst.inst_kind    = r_res.inst_kind;
    assign o_inst.operation    = r_res.operation;
    assign o_inst.dir_bit      = r_res.dir_bit;
    assign o_inst.wide_bit     = r_res.wide_bit;
    assign o_inst.sign_bit     = r_res.sign_bit;
    assign o_inst.mode_field   = r_res.mode_field;
    assign o_inst.reg_num      = r_res.reg_num;
    assign o_inst.rm_field     = r_res.rm_field;
    assign o_inst.displacement = r_res.displacement;
    assign o_inst.immediate    = r_res.immediate;
    assign o_inst.inst_length  = r_res.inst_length;

endmodule

### hw/rtl/x86d_checker.sv
// ----------------------------------------------------------------------------
// x86d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module x86d_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         i_inst_kind,
    input logic [1:0]         i_operation,
    input logic [1:0]         i_mode_field,
    input logic [2:0]         i_reg_num,
    input logic [2:0]         i_rm_field,
    input logic signed [15:0] i_displacement,
    input logic [15:0]        i_immediate,
    input logic [2:0]         i_inst_length
);
    import x86d_pkg::*;

    `X86D_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_inst_kind) && $stable(i_immediate)
        && $stable(i_inst_length))

    `X86D_ASSERT_NOW(a_len_range, i_out_valid, i_inst_length != 3'd0 && i_inst_length != 3'd7)

    `X86D_ASSERT_NOW(a_invalid_empty, i_out_valid && i_inst_kind == KIND_INVALID,
        i_operation == OP_MOV && i_displacement == 16'sd0 && i_immediate == 16'd0)

    `X86D_ASSERT_NOW(a_acc_fields, i_out_valid && i_inst_kind == KIND_IMM_ACC,
        i_reg_num == 3'd0 && i_mode_field == 2'd0 && i_rm_field == 3'd0
        && i_inst_length != 3'd1)

endmodule

bind x86_16bit_instruction_decoder x86d_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_inst.valid),
    .i_out_ready    (o_inst.ready),
    .i_inst_kind    (o_inst.inst_kind),
    .i_operation    (o_inst.operation),
    .i_mode_field   (o_inst.mode_field),
    .i_reg_num      (o_inst.reg_num),
    .i_rm_field     (o_inst.rm_field),
    .i_displacement (o_inst.displacement),
    .i_immediate    (o_inst.immediate),
    .i_inst_length  (o_inst.inst_length)
);
